// ===== hdl/msre_pkg.sv =====
`timescale 1ns / 1ps

package msre_pkg;

  localparam int unsigned MaxSegments = 16;
  localparam int unsigned SlotW       = $clog2(MaxSegments);
  localparam int unsigned SegW        = $clog2(MaxSegments + 1);
  localparam int unsigned DataW       = 32;
  localparam int unsigned FracW       = 16;
  localparam int unsigned StepW       = $clog2(FracW + 1);
  localparam int unsigned CfgIdxW     = 3;

  localparam logic [SegW-1:0]  MaxSegCount = SegW'(MaxSegments);
  localparam logic [StepW-1:0] StepCount   = StepW'(FracW);

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_LOAD  = 2'd3
  } cmd_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SEG_COUNT    = 3'd0,
    CFG_INIT_LEVEL   = 3'd1,
    CFG_TGT_OVR_ON   = 3'd2,
    CFG_TGT_OVR      = 3'd3,
    CFG_DUR_OVR_ON   = 3'd4,
    CFG_DUR_OVR      = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_CHECK,
    ST_DIV,
    ST_MUL,
    ST_PUSH
  } state_t;

endpackage

// ===== hdl/msre_chan_if.sv =====
`timescale 1ns / 1ps

interface msre_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] tick_time;
  logic [3:0]  slot;
  logic signed [31:0] slot_target;
  logic [31:0] slot_duration;

  modport source (output valid, command, tick_time, slot, slot_target, slot_duration,
                  input ready);
  modport sink   (input valid, command, tick_time, slot, slot_target, slot_duration,
                  output ready);
endinterface

interface msre_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] level;
  logic        level_written;
  logic        still_running;

  modport source (output valid, level, level_written, still_running, input ready);
  modport sink   (input valid, level, level_written, still_running, output ready);
endinterface

interface msre_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/msre_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle: quo = floor(num * 2^16 / den), num < den.
module msre_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [msre_pkg::DataW-1:0]  num,
  input  logic [msre_pkg::DataW-1:0]  den,
  output logic                        done,
  output logic [msre_pkg::FracW-1:0]  quo
);
  import msre_pkg::*;

  logic [DataW-1:0] rem_r, rem_nxt;
  logic [DataW-1:0] den_r, den_nxt;
  logic [FracW-1:0] quo_r, quo_nxt;
  logic [StepW-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [DataW:0] rem2;
  logic [DataW:0] sub;
  logic           ge;

  always_comb begin
    rem2 = {rem_r, 1'b0};
    sub  = rem2 - {1'b0, den_r};
    ge   = (rem2 >= {1'b0, den_r});
  end

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num;
      den_nxt  = den;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in one quotient bit, keep the partial remainder below den
      rem_nxt = ge ? sub[DataW-1:0] : rem2[DataW-1:0];
      quo_nxt = {quo_r[FracW-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == StepCount - 1'b1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== hdl/msre_mul.sv =====
`timescale 1ns / 1ps

// Bit-serial signed x unsigned multiply, LSB first, returning floor(diff * t / 2^16).
// The arithmetic shift each step drops one product bit, which floors exactly.
module msre_mul (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [msre_pkg::DataW:0]    diff,
  input  logic [msre_pkg::FracW-1:0]         mult,
  output logic                               done,
  output logic signed [msre_pkg::DataW:0]    q
);
  import msre_pkg::*;

  logic signed [DataW+1:0] acc_r, acc_nxt;
  logic signed [DataW:0]   diff_r, diff_nxt;
  logic [FracW-1:0]        t_r, t_nxt;
  logic [StepW-1:0]        cnt_r, cnt_nxt;
  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;

  logic signed [DataW+1:0] sum;

  always_comb begin
    sum = acc_r + (t_r[0] ? {diff_r[DataW], diff_r} : '0);
  end

  always_comb begin
    acc_nxt  = acc_r;
    diff_nxt = diff_r;
    t_nxt    = t_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      diff_nxt = diff;
      t_nxt    = mult;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = sum >>> 1;
      t_nxt   = {1'b0, t_r[FracW-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == StepCount - 1'b1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    diff_r <= diff_nxt;
    t_r    <= t_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign q    = acc_r[DataW:0];

endmodule

// ===== hdl/multi_segment_ramp_envelope_core.sv =====
// Start, stop and load words take effect on accept and return no result word.
// A tick word returns one result: an idle envelope goes from the tick step to the push
// step; otherwise a check step follows, and mid-ramp a 16-step serial divider and a
// 16-step serial multiply run before the push. One word at a time: after a tick no word is
// accepted until its result enters the output register; a held output stalls it in push.
// Synchronous active-low reset clears envelope and config state, not the table or payloads.
`timescale 1ns / 1ps

module multi_segment_ramp_envelope_core (
  input  logic       clk,
  input  logic       rst_n,
  msre_in_if.sink    in_chan,
  msre_out_if.source out_chan,
  msre_cfg_if.sink   cfg_chan
);
  import msre_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [SegW-1:0]         seg_count_r, seg_count_nxt;
  logic signed [DataW-1:0] init_level_r, init_level_nxt;
  logic                    tgt_ovr_on_r, tgt_ovr_on_nxt;
  logic signed [DataW-1:0] tgt_ovr_r, tgt_ovr_nxt;
  logic                    dur_ovr_on_r, dur_ovr_on_nxt;
  logic [DataW-1:0]        dur_ovr_r, dur_ovr_nxt;

  // ---------------------------------------------------------------------------
  // Envelope state
  // ---------------------------------------------------------------------------
  state_t                  state_r, state_nxt;
  logic                    active_r, active_nxt;
  logic [SegW-1:0]         seg_num_r, seg_num_nxt;
  logic [DataW-1:0]        time_r, time_nxt;
  logic [DataW-1:0]        len_r, len_nxt;
  logic signed [DataW-1:0] from_r, from_nxt;
  logic signed [DataW-1:0] to_r, to_nxt;
  logic                    repl_r, repl_nxt;
  logic signed [DataW-1:0] repl_level_r, repl_level_nxt;
  logic [DataW-1:0]        tick_r, tick_nxt;

  // segment table: no reset, entries are defined once loaded
  logic signed [DataW-1:0] tbl_tgt_r [MaxSegments];
  logic [DataW-1:0]        tbl_dur_r [MaxSegments];

  // result being built, and the output register
  logic signed [DataW-1:0] res_level_r, res_level_nxt;
  logic                    res_written_r, res_written_nxt;
  logic                    res_running_r, res_running_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [DataW-1:0] out_level_r, out_level_nxt;
  logic                    out_written_r, out_written_nxt;
  logic                    out_running_r, out_running_nxt;

  // handshake and unit control
  logic in_fire;
  logic cfg_fire;
  logic push_ok;
  logic div_start, div_done;
  logic mul_start, mul_done;
  logic [FracW-1:0]        div_quo;
  logic signed [DataW:0]   mul_q;
  logic signed [DataW:0]   ramp_diff;

  // datapath helpers
  cmd_t                    cmd;
  logic [SegW-1:0]         cnt_eff;
  logic [SegW-1:0]         seg_inc;
  logic [SlotW-1:0]        rd_idx;
  logic signed [DataW-1:0] tgt_rd;
  logic [DataW-1:0]        dur_rd;
  logic [DataW:0]          time_sum;

  assign cmd      = cmd_t'(in_chan.command);
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign cfg_fire = cfg_chan.valid && cfg_chan.ready;
  assign push_ok  = !out_valid_r || out_chan.ready;

  // a count above the table depth acts as the full table
  assign cnt_eff  = (seg_count_r > MaxSegCount) ? MaxSegCount : seg_count_r;
  assign seg_inc  = seg_num_r + 1'b1;

  // one table read port: entry zero at start, the next segment on advance
  assign rd_idx   = (state_r == ST_CHECK) ? seg_inc[SlotW-1:0] : '0;
  assign tgt_rd   = tgt_ovr_on_r ? tgt_ovr_r : tbl_tgt_r[rd_idx];
  assign dur_rd   = dur_ovr_on_r ? dur_ovr_r : tbl_dur_r[rd_idx];

  assign time_sum  = {1'b0, time_r} + {1'b0, tick_r};
  assign ramp_diff = {to_r[DataW-1], to_r} - {from_r[DataW-1], from_r};

  // ---------------------------------------------------------------------------
  // Serial arithmetic units
  // ---------------------------------------------------------------------------
  msre_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (time_r),
    .den   (len_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  msre_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .diff  (ramp_diff),
    .mult  (div_quo),
    .done  (mul_done),
    .q     (mul_q)
  );

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && cmd == CMD_TICK) state_nxt = ST_TICK;
      end
      ST_TICK: begin
        // idle envelope answers at once
        if (!active_r || cnt_eff == '0) state_nxt = ST_PUSH;
        else                            state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (time_r >= len_r) state_nxt = ST_PUSH;
        else                 state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (mul_done) state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (push_ok) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // State machine outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_chan.ready  = 1'b0;
    cfg_chan.ready = 1'b1;
    div_start      = 1'b0;
    mul_start      = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_chan.ready = 1'b1;
      ST_CHECK: div_start     = (time_r < len_r);
      ST_DIV:   mul_start     = div_done;
      ST_TICK, ST_MUL, ST_PUSH: ;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  always_comb begin
    seg_count_nxt   = seg_count_r;
    init_level_nxt  = init_level_r;
    tgt_ovr_on_nxt  = tgt_ovr_on_r;
    tgt_ovr_nxt     = tgt_ovr_r;
    dur_ovr_on_nxt  = dur_ovr_on_r;
    dur_ovr_nxt     = dur_ovr_r;
    active_nxt      = active_r;
    seg_num_nxt     = seg_num_r;
    time_nxt        = time_r;
    len_nxt         = len_r;
    from_nxt        = from_r;
    to_nxt          = to_r;
    repl_nxt        = repl_r;
    repl_level_nxt  = repl_level_r;
    tick_nxt        = tick_r;
    res_level_nxt   = res_level_r;
    res_written_nxt = res_written_r;
    res_running_nxt = res_running_r;
    out_valid_nxt   = out_valid_r;
    out_level_nxt   = out_level_r;
    out_written_nxt = out_written_r;
    out_running_nxt = out_running_r;

    // drop the output word once taken
    if (out_valid_r && out_chan.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (cmd)
            CMD_TICK: tick_nxt = in_chan.tick_time;
            CMD_START: begin
              if (cnt_eff == '0) begin
                active_nxt = 1'b0;
              end else begin
                active_nxt  = 1'b1;
                seg_num_nxt = '0;
                from_nxt    = repl_r ? repl_level_r : init_level_r;
                to_nxt      = tgt_rd;
                len_nxt     = dur_rd;
                time_nxt    = '0;
                // a zero-length first segment moves the start level for later runs
                if (dur_rd == '0) begin
                  repl_nxt       = 1'b1;
                  repl_level_nxt = tgt_rd;
                end
              end
            end
            CMD_STOP: active_nxt = 1'b0;
            CMD_LOAD: ;
            default: ;
          endcase
        end
      end
      ST_TICK: begin
        if (!active_r || cnt_eff == '0) begin
          active_nxt      = 1'b0;
          res_level_nxt   = '0;
          res_written_nxt = 1'b0;
          res_running_nxt = 1'b0;
        end else begin
          // saturate elapsed time
          time_nxt = time_sum[DataW] ? '1 : time_sum[DataW-1:0];
        end
      end
      ST_CHECK: begin
        if (time_r >= len_r) begin
          // segment complete: land on the target exactly and advance
          from_nxt        = to_r;
          res_level_nxt   = to_r;
          res_written_nxt = 1'b1;
          seg_num_nxt     = seg_inc;
          if (seg_inc >= cnt_eff) begin
            active_nxt      = 1'b0;
            res_running_nxt = 1'b0;
          end else begin
            to_nxt          = tgt_rd;
            len_nxt         = dur_rd;
            time_nxt        = '0;
            res_running_nxt = 1'b1;
            if (dur_rd == '0) res_level_nxt = tgt_rd;
          end
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          res_level_nxt   = from_r + mul_q[DataW-1:0];
          res_written_nxt = 1'b1;
          res_running_nxt = 1'b1;
        end
      end
      ST_PUSH: begin
        if (push_ok) begin
          out_valid_nxt   = 1'b1;
          out_level_nxt   = res_level_r;
          out_written_nxt = res_written_r;
          out_running_nxt = res_running_r;
        end
      end
      ST_DIV: ;
      default: ;
    endcase

    if (cfg_fire) begin
      unique case (cfg_idx_t'(cfg_chan.index))
        CFG_SEG_COUNT:  seg_count_nxt  = cfg_chan.data[SegW-1:0];
        CFG_INIT_LEVEL: begin
          init_level_nxt = cfg_chan.data;
          repl_nxt       = 1'b0;
        end
        CFG_TGT_OVR_ON: tgt_ovr_on_nxt = cfg_chan.data[0];
        CFG_TGT_OVR:    tgt_ovr_nxt    = cfg_chan.data;
        CFG_DUR_OVR_ON: dur_ovr_on_nxt = cfg_chan.data[0];
        CFG_DUR_OVR:    dur_ovr_nxt    = cfg_chan.data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      seg_count_r   <= '0;
      init_level_r  <= '0;
      tgt_ovr_on_r  <= 1'b0;
      tgt_ovr_r     <= '0;
      dur_ovr_on_r  <= 1'b0;
      dur_ovr_r     <= '0;
      active_r      <= 1'b0;
      seg_num_r     <= '0;
      time_r        <= '0;
      len_r         <= '0;
      from_r        <= '0;
      to_r          <= '0;
      repl_r        <= 1'b0;
      repl_level_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      seg_count_r   <= seg_count_nxt;
      init_level_r  <= init_level_nxt;
      tgt_ovr_on_r  <= tgt_ovr_on_nxt;
      tgt_ovr_r     <= tgt_ovr_nxt;
      dur_ovr_on_r  <= dur_ovr_on_nxt;
      dur_ovr_r     <= dur_ovr_nxt;
      active_r      <= active_nxt;
      seg_num_r     <= seg_num_nxt;
      time_r        <= time_nxt;
      len_r         <= len_nxt;
      from_r        <= from_nxt;
      to_r          <= to_nxt;
      repl_r        <= repl_nxt;
      repl_level_r  <= repl_level_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    tick_r        <= tick_nxt;
    res_level_r   <= res_level_nxt;
    res_written_r <= res_written_nxt;
    res_running_r <= res_running_nxt;
    out_level_r   <= out_level_nxt;
    out_written_r <= out_written_nxt;
    out_running_r <= out_running_nxt;
  end

  // segment table write on a load word
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_fire && cmd == CMD_LOAD) begin
      tbl_tgt_r[in_chan.slot] <= in_chan.slot_target;
      tbl_dur_r[in_chan.slot] <= in_chan.slot_duration;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.level         = out_level_r;
  assign out_chan.level_written = out_written_r;
  assign out_chan.still_running = out_running_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_idle_word_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_written_r |-> out_level_r == '0 && !out_running_r)
    else $error("idle tick word carries a level or running flag");

  a_running_matches: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PUSH && push_ok |=> out_running_r == active_r)
    else $error("still_running disagrees with envelope state");

  a_seg_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    seg_num_r <= MaxSegCount)
    else $error("segment number beyond table");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside divide phase");

  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == ST_MUL)
    else $error("multiplier finished outside multiply phase");

endmodule

// ===== sim/tb_multi_segment_ramp_envelope_core.sv =====
`timescale 1ns / 1ps

module tb_multi_segment_ramp_envelope_core;
  import msre_pkg::*;

  localparam int unsigned CycleLimit   = 1000000;
  localparam int unsigned RandomWords  = 1750;
  localparam int unsigned SettleCycles = 45;   // longer than the mid-ramp tick latency
  localparam int unsigned HoldCycles   = 300;  // long output stall for the fill-up test

  // One expected result word of a tick.
  typedef struct packed {
    logic signed [31:0] level;
    logic               written;
    logic               running;
  } level_word_t;

  logic clk = 1'b0;
  logic rst_n;

  msre_in_if  in_bus ();
  msre_out_if out_bus ();
  msre_cfg_if cfg_bus ();

  multi_segment_ramp_envelope_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  always #1 clk = ~clk;

  // Expected levels, oldest first, and the failure tally.
  level_word_t pending_levels[$];
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;

  // Idle switches for both sides, and the toggle that asks the receiver for a long hold.
  bit in_gaps  = 1'b1;
  bit out_gaps = 1'b1;
  bit hold_toggle = 1'b0;
  bit hold_seen;
  int unsigned hold_left;

  // ---------------------------------------------------------------------------
  // Envelope predictor: registers, running state and segment table.
  // ---------------------------------------------------------------------------
  logic [4:0]         prog_count      = '0;
  logic signed [31:0] start_level_cfg = '0;
  bit                 tgt_ovr_on      = 1'b0;
  logic signed [31:0] tgt_ovr_val     = '0;
  bit                 dur_ovr_on      = 1'b0;
  logic [31:0]        dur_ovr_val     = '0;

  bit                 env_active      = 1'b0;
  int unsigned        seg_idx         = 0;
  logic [31:0]        seg_elapsed     = '0;
  logic [31:0]        seg_len         = '0;
  logic signed [31:0] ramp_start      = '0;
  logic signed [31:0] ramp_end        = '0;
  logic signed [31:0] tbl_tgt [MaxSegments];
  logic [31:0]        tbl_dur [MaxSegments];
  bit                 lvl_replaced    = 1'b0;
  logic signed [31:0] lvl_replacement = '0;

  // Clamp the programmed count to the table size.
  function automatic int unsigned effective_count();
    return (prog_count > MaxSegments) ? MaxSegments : int'(prog_count);
  endfunction

  // Latch target and duration of a segment, honoring the overrides.
  function automatic void enter_segment(int unsigned idx);
    ramp_end    = tgt_ovr_on ? tgt_ovr_val : tbl_tgt[idx];
    seg_len     = dur_ovr_on ? dur_ovr_val : tbl_dur[idx];
    seg_elapsed = '0;
  endfunction

  // Linear point between ramp_start and ramp_end; the product is floored.
  function automatic logic signed [31:0] ramp_point();
    longint unsigned frac;
    longint          span;
    longint          prod;
    if (seg_len == 0 || seg_elapsed >= seg_len) begin
      frac = 64'd65536;
    end else begin
      frac = {16'd0, seg_elapsed, 16'd0} / {32'd0, seg_len};
    end
    span = longint'(ramp_end) - longint'(ramp_start);
    prod = span * longint'(frac);
    return 32'(longint'(ramp_start) + (prod >>> 16));
  endfunction

  function automatic void apply_register(cfg_idx_t idx, logic [31:0] val);
    case (idx)
      CFG_SEG_COUNT:  prog_count = val[4:0];
      CFG_INIT_LEVEL: begin
        start_level_cfg = val;
        lvl_replaced    = 1'b0;
      end
      CFG_TGT_OVR_ON: tgt_ovr_on  = val[0];
      CFG_TGT_OVR:    tgt_ovr_val = val;
      CFG_DUR_OVR_ON: dur_ovr_on  = val[0];
      CFG_DUR_OVR:    dur_ovr_val = val;
      default: ;
    endcase
  endfunction

  // Advance the predictor by one accepted word; a tick queues one expected result.
  function automatic void advance_envelope(cmd_t cmd, logic [31:0] tick_time, logic [3:0] slot,
                                           logic signed [31:0] target, logic [31:0] duration);
    level_word_t w;
    logic [32:0] sum;
    case (cmd)
      CMD_START: begin
        if (effective_count() == 0) begin
          env_active = 1'b0;
        end else begin
          env_active = 1'b1;
          seg_idx    = 0;
          ramp_start = lvl_replaced ? lvl_replacement : start_level_cfg;
          enter_segment(0);
          // A zero-length opening segment also moves the start level of later runs.
          if (seg_len == 0) begin
            lvl_replaced    = 1'b1;
            lvl_replacement = ramp_end;
          end
        end
      end
      CMD_STOP: env_active = 1'b0;
      CMD_LOAD: begin
        tbl_tgt[slot] = target;
        tbl_dur[slot] = duration;
      end
      default: begin
        if (!env_active || effective_count() == 0) begin
          env_active = 1'b0;
          w = '{level: '0, written: 1'b0, running: 1'b0};
        end else begin
          // Saturate elapsed time at all ones.
          sum         = {1'b0, seg_elapsed} + {1'b0, tick_time};
          seg_elapsed = sum[32] ? '1 : sum[31:0];
          w.level     = ramp_point();
          if (seg_elapsed >= seg_len) begin
            ramp_start = ramp_end;
            w.level    = ramp_end;
            seg_idx++;
            if (seg_idx >= effective_count()) begin
              env_active = 1'b0;
            end else begin
              enter_segment(seg_idx);
              if (seg_len == 0) w.level = ramp_end;
            end
          end
          w.written = 1'b1;
          w.running = env_active;
        end
        pending_levels.push_back(w);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Random field pickers.
  // ---------------------------------------------------------------------------
  // Times and durations: zero, all ones, short spans, or anything.
  function automatic logic [31:0] pick_span();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 15) return '0;
    if (roll < 30) return '1;
    if (roll < 70) return $urandom_range(1, 32'h0003_0000);
    return $urandom;
  endfunction

  function automatic logic signed [31:0] pick_level();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return 32'sh8000_0000;
    if (roll < 20) return 32'sh7FFF_FFFF;
    if (roll < 30) return '0;
    return $urandom;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers.
  // ---------------------------------------------------------------------------
  // Offer one word and hold it until accepted; valid stays high for back-to-back words.
  task automatic send_word(cmd_t cmd, logic [31:0] tick_time, logic [3:0] slot,
                           logic signed [31:0] target, logic [31:0] duration);
    if (in_gaps && $urandom_range(99) < 15) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.command       <= cmd;
    in_bus.tick_time     <= tick_time;
    in_bus.slot          <= slot;
    in_bus.slot_target   <= target;
    in_bus.slot_duration <= duration;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    advance_envelope(cmd, tick_time, slot, target, duration);
  endtask

  // Unused fields carry noise so the block has to ignore them.
  task automatic send_tick(logic [31:0] tick_time);
    send_word(CMD_TICK, tick_time, 4'($urandom), $urandom, $urandom);
  endtask

  task automatic send_ctrl(cmd_t cmd);
    send_word(cmd, $urandom, 4'($urandom), $urandom, $urandom);
  endtask

  task automatic send_load(logic [3:0] slot, logic signed [31:0] target, logic [31:0] duration);
    send_word(CMD_LOAD, $urandom, slot, target, duration);
  endtask

  // Write one register; drop valid afterward so the next write starts in a fresh step.
  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    apply_register(idx, val);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drop input valid, wait for every expected level, then let any in-flight word finish.
  task automatic settle_block();
    in_bus.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: compare each accepted result with the oldest expectation and drive ready.
  // ---------------------------------------------------------------------------
  task automatic check_level_word();
    level_word_t want;
    if (pending_levels.size() == 0) begin
      $error("unexpected result word: level %0d written %0b running %0b",
             out_bus.level, out_bus.level_written, out_bus.still_running);
      fail_count++;
    end else begin
      want = pending_levels.pop_front();
      if (out_bus.level !== want.level) begin
        $error("level: expected %0d, got %0d", want.level, out_bus.level);
        fail_count++;
      end
      if (out_bus.level_written !== want.written) begin
        $error("level_written: expected %0b, got %0b", want.written, out_bus.level_written);
        fail_count++;
      end
      if (out_bus.still_running !== want.running) begin
        $error("still_running: expected %0b, got %0b", want.running, out_bus.still_running);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      hold_left     <= 0;
      hold_seen     <= hold_toggle;
    end else begin
      if (out_bus.valid && out_bus.ready) check_level_word();
      // A new toggle starts a long hold; otherwise stall at random when allowed.
      if (hold_toggle != hold_seen) begin
        hold_seen     <= hold_toggle;
        hold_left     <= HoldCycles;
        out_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= !(out_gaps && $urandom_range(99) < 15);
      end
    end
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------
  // Ticks with nothing programmed answer idle; a start with a zero count does nothing.
  task automatic test_idle_ticks();
    send_tick('0);
    send_ctrl(CMD_START);
    send_tick('1);
  endtask

  // Fill every slot before any segment can read the table, with corner values up front.
  task automatic test_table_load();
    send_load(4'd0, 32'sh7FFF_FFFF, 32'h0000_0000);  // zero-length opening segment
    send_load(4'd1, 32'sh8000_0000, 32'h0001_0000);  // ramp down to the floor
    send_load(4'd2, 32'sh0000_0000, 32'h0000_0000);  // zero-length inner segment
    send_load(4'd3, 32'sh1234_5678, 32'hFFFF_FFFF);  // longest duration
    for (int s = 4; s < MaxSegments; s++) begin
      send_load(4'(s), pick_level(), pick_span());
    end
  endtask

  // Walk the corner segments: start level swap, half step, saturation, zero-length entry.
  task automatic test_segment_walk();
    settle_block();
    write_reg(CFG_SEG_COUNT, 32'd4);
    write_reg(CFG_INIT_LEVEL, 32'h8000_0000);
    send_ctrl(CMD_START);
    send_tick(32'h0000_8000);
    send_tick(32'h0000_8000);
    send_tick(32'hFFFF_FFFF);
    send_tick(32'h0000_0000);
    send_tick(32'h7FFF_FFFF);
    send_ctrl(CMD_STOP);
    send_tick(32'h0000_0001);
    // Restart ramps from the level left by the zero-length opening segment.
    send_ctrl(CMD_START);
    send_tick(32'h0000_0000);
  endtask

  // Global overrides at their extremes, with a count above the table size.
  task automatic test_overrides();
    settle_block();
    write_reg(CFG_SEG_COUNT, 32'd31);
    write_reg(CFG_TGT_OVR_ON, 32'd1);
    write_reg(CFG_TGT_OVR, 32'h8000_0000);
    write_reg(CFG_DUR_OVR_ON, 32'd1);
    write_reg(CFG_DUR_OVR, 32'hFFFF_FFFF);
    send_ctrl(CMD_START);
    send_tick(32'h8000_0000);
    send_tick(32'hFFFF_FFFF);
    send_tick(32'h0000_1000);
    settle_block();
    write_reg(CFG_TGT_OVR, 32'h7FFF_FFFF);
    write_reg(CFG_DUR_OVR, 32'h0000_0000);
    send_ctrl(CMD_START);
    repeat (18) send_tick($urandom);
    settle_block();
    write_reg(CFG_TGT_OVR_ON, 32'd0);
    write_reg(CFG_DUR_OVR_ON, 32'd0);
    write_reg(CFG_INIT_LEVEL, 32'h7FFF_FFFF);
  endtask

  // Hold the output for a long stretch while ticks keep coming, so the block fills up.
  task automatic test_output_backpressure();
    settle_block();
    write_reg(CFG_SEG_COUNT, 32'd16);
    send_ctrl(CMD_START);
    hold_toggle <= ~hold_toggle;
    repeat (12) send_tick(pick_span());
  endtask

  // Pick a fresh mix of register values; zero counts stay rare.
  task automatic shuffle_regs();
    int unsigned roll;
    if ($urandom_range(1) == 1) begin
      roll = $urandom_range(99);
      if (roll < 5) write_reg(CFG_SEG_COUNT, 32'd0);
      else if (roll < 15) write_reg(CFG_SEG_COUNT, 32'($urandom_range(17, 31)));
      else if (roll < 25) write_reg(CFG_SEG_COUNT, 32'd16);
      else write_reg(CFG_SEG_COUNT, 32'($urandom_range(1, 16)));
    end
    if ($urandom_range(3) == 0) write_reg(CFG_INIT_LEVEL, pick_level());
    if ($urandom_range(3) == 0) write_reg(CFG_TGT_OVR_ON, 32'($urandom_range(99) < 20));
    if ($urandom_range(3) == 0) write_reg(CFG_TGT_OVR, pick_level());
    if ($urandom_range(3) == 0) write_reg(CFG_DUR_OVR_ON, 32'($urandom_range(99) < 20));
    if ($urandom_range(3) == 0) write_reg(CFG_DUR_OVR, pick_span());
  endtask

  // Bursts of mostly well-formed programs: a start, then ticks with stray
  // loads, stops and restarts mixed in.
  task automatic test_random_programs();
    int unsigned sent;
    int unsigned phase;
    int unsigned burst;
    int unsigned roll;
    sent  = 0;
    phase = 0;
    while (sent < RandomWords) begin
      settle_block();
      // A run of phases with no idling on either side.
      in_gaps  = (phase < 8 || phase > 12);
      out_gaps = in_gaps;
      shuffle_regs();
      burst = $urandom_range(30, 70);
      send_ctrl(CMD_START);
      for (int i = 1; i < burst; i++) begin
        roll = $urandom_range(99);
        if (roll < 6) send_load(4'($urandom), pick_level(), pick_span());
        else if (roll < 10) send_ctrl(CMD_START);
        else if (roll < 13) send_ctrl(CMD_STOP);
        else send_tick(pick_span());
      end
      sent += burst;
      phase++;
    end
    in_gaps  = 1'b1;
    out_gaps = 1'b1;
  endtask

  initial begin
    rst_n                = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.command       = CMD_TICK;
    in_bus.tick_time     = '0;
    in_bus.slot          = '0;
    in_bus.slot_target   = '0;
    in_bus.slot_duration = '0;
    out_bus.ready        = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = CFG_SEG_COUNT;
    cfg_bus.data         = '0;
    for (int s = 0; s < MaxSegments; s++) begin
      tbl_tgt[s] = '0;
      tbl_dur[s] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_ticks();
    test_table_load();
    test_segment_walk();
    test_overrides();
    test_output_backpressure();
    test_random_programs();
    settle_block();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
